// ===== sv/sorted_key_index_table_core_defines.svh =====
// Assertion macros used by the checker file.
`ifndef SORTED_KEY_INDEX_TABLE_CORE_DEFINES_SVH
`define SORTED_KEY_INDEX_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, ignored during reset
`define SKIT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("skit assertion failed");

// Next-cycle implication, ignored during reset
`define SKIT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("skit assertion failed");

// Next-cycle implication that also holds across reset
`define SKIT_ASSERT_NXT_ALL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("skit assertion failed");

`endif

// ===== sv/skit_pkg.sv =====
// Types and codes shared by the sorted key index table files.
package skit_pkg;

  localparam int KEY_W   = 31;
  localparam int POS_W   = 63;
  localparam int RANK_W  = 8;
  localparam int COUNT_W = 9;

  localparam logic [1:0] REQ_PUT      = 2'd0;
  localparam logic [1:0] REQ_GET_KEY  = 2'd1;
  localparam logic [1:0] REQ_GET_RANK = 2'd2;
  localparam logic [1:0] REQ_IGNORED  = 2'd3;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND  = 2'd1;
  localparam logic [1:0] ST_TABLE_FULL = 2'd2;
  localparam logic [1:0] ST_LIST_FULL  = 2'd3;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [KEY_W-1:0]  key;
    logic [POS_W-1:0]  pos;
    logic [RANK_W-1:0] rank;
  } skit_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [KEY_W-1:0]   key_out;
    logic [POS_W-1:0]   pos_out;
    logic [COUNT_W-1:0] count;
    logic               last;
  } skit_rsp_t;

  // Command broadcast to every cell of the row
  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_CMP   = 3'd1,
    CMD_SWEEP = 3'd2,
    CMD_INS   = 3'd3,
    CMD_INC   = 3'd4
  } skit_cmd_t;

  typedef struct packed {
    skit_cmd_t         cmd;
    logic [KEY_W-1:0]  key;
    logic [RANK_W-1:0] rank;
    logic              by_rank;
  } skit_ctl_t;

endpackage

// ===== sv/skit_stream_if.sv =====
// Valid/ready stream channel carrying one word per handshake.
interface skit_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/sorted_key_index_table_core.sv =====
// Put: from accept, the request passes compare, a sweep through the cell row,
// decide and result.
// Get: compare, sweep and decide find the entry, then each position is read
// from the position RAM in read, capture and handshake steps.
// One request at a time; a new word is taken only once the last result left.
// Reset (synchronous) empties the table; RAM contents are not cleared.
module sorted_key_index_table_core #(
  parameter int MAX_KEYS        = 256,
  parameter int MAX_POS_PER_KEY = 16
) (
  input logic   clk,
  input logic   rst,
  skit_stream_if.sink   in_ch,
  skit_stream_if.source out_ch
);
  import skit_pkg::*;

  localparam int SW = (MAX_KEYS > 2) ? $clog2(MAX_KEYS) : 1;
  localparam int LW = $clog2(MAX_POS_PER_KEY + 1);
  localparam int CW = $clog2(MAX_KEYS + 1);
  localparam int DEPTH = MAX_KEYS * MAX_POS_PER_KEY;
  localparam int AW = (DEPTH > 2) ? $clog2(DEPTH) : 1;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CMP   = 7'b0000010,
    S_SWEEP = 7'b0000100,
    S_DEC   = 7'b0001000,
    S_RD    = 7'b0010000,
    S_EMIT  = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state, state_next;

  logic [1:0]        r_req;
  logic [KEY_W-1:0]  r_key;
  logic [POS_W-1:0]  r_pos;
  logic [RANK_W-1:0] r_rank;
  logic [CW-1:0]     key_count;
  logic [SW-1:0]     sweep_cnt;
  logic [KEY_W-1:0]  e_key;
  logic [SW-1:0]     e_slot;
  logic [LW-1:0]     e_len;
  logic [LW-1:0]     e_idx;
  logic              more;
  skit_rsp_t         o_data;
  skit_ctl_t         ctl;

  // Cell row wiring
  logic              c_vld   [MAX_KEYS];
  logic [KEY_W-1:0]  c_key   [MAX_KEYS];
  logic [SW-1:0]     c_slot  [MAX_KEYS];
  logic [LW-1:0]     c_len   [MAX_KEYS];
  logic              c_lt    [MAX_KEYS];
  logic              c_shf   [MAX_KEYS];
  logic              c_bfnd  [MAX_KEYS];
  logic [KEY_W-1:0]  c_bkey  [MAX_KEYS];
  logic [SW-1:0]     c_bslot [MAX_KEYS];
  logic [LW-1:0]     c_blen  [MAX_KEYS];

  logic              b_fnd;
  logic [KEY_W-1:0]  b_key;
  logic [SW-1:0]     b_slot;
  logic [LW-1:0]     b_len;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [AW-1:0]     ram_raddr;
  logic [POS_W-1:0]  ram_rdata;

  for (genvar i = 0; i < MAX_KEYS; i++) begin : g_cell
    if (i == 0) begin : g_first
      skit_cell #(.IDX(i), .SW(SW), .LW(LW)) u_cell (
        .clk, .rst, .ctl, .new_slot(key_count[SW-1:0]),
        .l_vld(1'b0), .l_key('0), .l_slot('0), .l_len('0),
        .l_lt(1'b1), .l_shf(1'b0),
        .l_bfnd(1'b0), .l_bkey('0), .l_bslot('0), .l_blen('0),
        .vld(c_vld[i]), .key(c_key[i]), .slot(c_slot[i]), .len(c_len[i]),
        .lt(c_lt[i]), .shf(c_shf[i]),
        .bfnd(c_bfnd[i]), .bkey(c_bkey[i]), .bslot(c_bslot[i]), .blen(c_blen[i])
      );
    end else begin : g_rest
      skit_cell #(.IDX(i), .SW(SW), .LW(LW)) u_cell (
        .clk, .rst, .ctl, .new_slot(key_count[SW-1:0]),
        .l_vld(c_vld[i-1]), .l_key(c_key[i-1]), .l_slot(c_slot[i-1]),
        .l_len(c_len[i-1]), .l_lt(c_lt[i-1]), .l_shf(c_shf[i-1]),
        .l_bfnd(c_bfnd[i-1]), .l_bkey(c_bkey[i-1]), .l_bslot(c_bslot[i-1]),
        .l_blen(c_blen[i-1]),
        .vld(c_vld[i]), .key(c_key[i]), .slot(c_slot[i]), .len(c_len[i]),
        .lt(c_lt[i]), .shf(c_shf[i]),
        .bfnd(c_bfnd[i]), .bkey(c_bkey[i]), .bslot(c_bslot[i]), .blen(c_blen[i])
      );
    end
  end

  assign b_fnd  = c_bfnd[MAX_KEYS-1];
  assign b_key  = c_bkey[MAX_KEYS-1];
  assign b_slot = c_bslot[MAX_KEYS-1];
  assign b_len  = c_blen[MAX_KEYS-1];

  skit_ram #(.WIDTH(POS_W), .DEPTH(DEPTH)) u_pos_ram (
    .clk, .we(ram_we), .waddr(ram_waddr), .wdata(r_pos),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  assign ram_raddr = AW'(int'(e_slot) * MAX_POS_PER_KEY + int'(e_idx));

  // Decide the put action and the cell command
  always_comb begin
    ctl.cmd     = CMD_NONE;
    ctl.key     = r_key;
    ctl.rank    = r_rank;
    ctl.by_rank = (r_req == REQ_GET_RANK);
    ram_we      = 1'b0;
    ram_waddr   = AW'(int'(key_count) * MAX_POS_PER_KEY);
    unique case (state)
      S_CMP:   ctl.cmd = CMD_CMP;
      S_SWEEP: ctl.cmd = CMD_SWEEP;
      S_DEC: begin
        if (r_req == REQ_PUT) begin
          if (b_fnd) begin
            if (b_len < LW'(MAX_POS_PER_KEY)) begin
              ctl.cmd   = CMD_INC;
              ram_we    = 1'b1;
              ram_waddr = AW'(int'(b_slot) * MAX_POS_PER_KEY + int'(b_len));
            end
          end else if (key_count < CW'(MAX_KEYS)) begin
            ctl.cmd = CMD_INS;
            ram_we  = 1'b1;
          end
        end
      end
      S_IDLE, S_RD, S_EMIT, S_OUT: ctl.cmd = CMD_NONE;
      default: ctl.cmd = CMD_NONE;
    endcase
  end

  // Sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_ch.valid && in_ch.data.req_type != REQ_IGNORED) begin
          state_next = S_CMP;
        end
      end
      S_CMP: state_next = S_SWEEP;
      S_SWEEP: begin
        if (sweep_cnt == SW'(MAX_KEYS - 1)) begin
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        if (r_req != REQ_PUT && b_fnd) begin
          state_next = S_RD;
        end else begin
          state_next = S_OUT;
        end
      end
      S_RD:   state_next = S_EMIT;
      S_EMIT: state_next = S_OUT;
      S_OUT: begin
        if (out_ch.ready) begin
          state_next = more ? S_RD : S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Advance state and key count
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      key_count <= '0;
      sweep_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == S_SWEEP) begin
        sweep_cnt <= sweep_cnt + SW'(1);
      end else begin
        sweep_cnt <= '0;
      end
      if (ctl.cmd == CMD_INS) begin
        key_count <= key_count + CW'(1);
      end
    end
  end

  // Capture the request and build result words
  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_ch.valid) begin
      r_req  <= in_ch.data.req_type;
      r_key  <= in_ch.data.key;
      r_pos  <= in_ch.data.pos;
      r_rank <= in_ch.data.rank;
    end
    case (state)
      S_DEC: begin
        more           <= 1'b0;
        e_key          <= b_key;
        e_slot         <= b_slot;
        e_len          <= b_len;
        e_idx          <= '0;
        o_data.key_out <= r_key;
        o_data.pos_out <= r_pos;
        o_data.last    <= 1'b1;
        if (r_req == REQ_PUT) begin
          o_data.count <= COUNT_W'(key_count);
          if (b_fnd) begin
            o_data.status <= (b_len < LW'(MAX_POS_PER_KEY)) ? ST_OK : ST_LIST_FULL;
          end else if (key_count < CW'(MAX_KEYS)) begin
            o_data.status <= ST_OK;
            o_data.count  <= COUNT_W'(key_count + CW'(1));
          end else begin
            o_data.status <= ST_TABLE_FULL;
          end
        end else if (!b_fnd) begin
          o_data.status  <= ST_NOT_FOUND;
          o_data.pos_out <= '0;
          o_data.count   <= '0;
          if (r_req == REQ_GET_RANK) begin
            o_data.key_out <= '0;
          end
        end
      end
      S_EMIT: begin
        o_data.status  <= ST_OK;
        o_data.key_out <= e_key;
        o_data.pos_out <= ram_rdata;
        o_data.count   <= COUNT_W'(e_len);
        o_data.last    <= (e_idx + LW'(1) == e_len);
        more           <= (e_idx + LW'(1) != e_len);
      end
      S_OUT: begin
        if (out_ch.ready) begin
          e_idx <= e_idx + LW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  assign in_ch.ready  = (state == S_IDLE);
  assign out_ch.valid = (state == S_OUT);
  assign out_ch.data  = o_data;
endmodule

// ===== sv/skit_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module skit_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== sv/skit_cell.sv =====
// One entry of the sorted key row: key, slot pointer, list length and flags.
module skit_cell #(
  parameter int IDX = 0,
  parameter int SW  = 8,
  parameter int LW  = 5
) (
  input  logic                     clk,
  input  logic                     rst,
  input  skit_pkg::skit_ctl_t      ctl,
  input  logic [SW-1:0]            new_slot,
  input  logic                     l_vld,
  input  logic [skit_pkg::KEY_W-1:0] l_key,
  input  logic [SW-1:0]            l_slot,
  input  logic [LW-1:0]            l_len,
  input  logic                     l_lt,
  input  logic                     l_shf,
  input  logic                     l_bfnd,
  input  logic [skit_pkg::KEY_W-1:0] l_bkey,
  input  logic [SW-1:0]            l_bslot,
  input  logic [LW-1:0]            l_blen,
  output logic                     vld,
  output logic [skit_pkg::KEY_W-1:0] key,
  output logic [SW-1:0]            slot,
  output logic [LW-1:0]            len,
  output logic                     lt,
  output logic                     shf,
  output logic                     bfnd,
  output logic [skit_pkg::KEY_W-1:0] bkey,
  output logic [SW-1:0]            bslot,
  output logic [LW-1:0]            blen
);
  import skit_pkg::*;

  logic eq;
  logic place;
  logic hit;
  logic rank_hit;

  // Key order against the broadcast key; lt runs 1..1 0..0 along the row
  assign lt       = vld && (key < ctl.key);
  assign eq       = vld && (key == ctl.key);
  assign place    = !lt && l_lt;
  assign rank_hit = vld && (IDX == int'(ctl.rank));

  // Hold the entry; shift, insert or bump the length on command
  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= 1'b0;
      hit  <= 1'b0;
      shf  <= 1'b0;
      bfnd <= 1'b0;
    end else begin
      case (ctl.cmd)
        CMD_CMP: begin
          hit <= ctl.by_rank ? rank_hit : (place && eq);
          shf <= !lt;
        end
        CMD_SWEEP: begin
          if (hit) begin
            bfnd  <= 1'b1;
            bkey  <= key;
            bslot <= slot;
            blen  <= len;
          end else begin
            bfnd  <= l_bfnd;
            bkey  <= l_bkey;
            bslot <= l_bslot;
            blen  <= l_blen;
          end
        end
        CMD_INS: begin
          if (shf && !l_shf) begin
            vld  <= 1'b1;
            key  <= ctl.key;
            slot <= new_slot;
            len  <= LW'(1);
          end else if (shf) begin
            vld  <= l_vld;
            key  <= l_key;
            slot <= l_slot;
            len  <= l_len;
          end
        end
        CMD_INC: begin
          if (hit) begin
            len <= len + LW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end
endmodule

// ===== sv/skit_checker.sv =====
// Port-level checks for the sorted key index table, bound to the top level.
`include "sorted_key_index_table_core_defines.svh"

module skit_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input skit_pkg::skit_rsp_t out_data
);
  import skit_pkg::*;

  // No new word is taken while a result waits
  `SKIT_ASSERT_IMP(a_busy_no_accept, out_valid, !in_ready)
  // A stalled result word holds
  `SKIT_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  // A miss is a single empty result
  `SKIT_ASSERT_IMP(a_miss_single, out_valid && out_data.status == ST_NOT_FOUND,
                   out_data.last && out_data.count == '0 && in_valid == in_valid)
  // Reset leaves no result pending
  `SKIT_ASSERT_NXT_ALL(a_rst_clear, rst, !out_valid)
endmodule

bind sorted_key_index_table_core skit_checker u_skit_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(in_ch.valid),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_data(out_ch.data)
);

// ===== dv/tb_sorted_key_index_table_core.sv =====
// Testbench for the sorted key index table: directed and random puts and gets.
module tb_sorted_key_index_table_core;
  import skit_pkg::*;

  localparam int NKEYS = 256;
  localparam int NPOS  = 16;

  logic clk = 1'b0;
  logic rst = 1'b1;

  skit_stream_if #(.T(skit_req_t)) req_if ();
  skit_stream_if #(.T(skit_rsp_t)) rsp_if ();

  sorted_key_index_table_core #(
    .MAX_KEYS(NKEYS),
    .MAX_POS_PER_KEY(NPOS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .in_ch(req_if.sink),
    .out_ch(rsp_if.source)
  );

  always #5 clk = ~clk;

  // Shadow of the table contents
  logic [KEY_W-1:0]  tbl_key [NKEYS];
  int                tbl_slot [NKEYS];
  int                tbl_len [NKEYS];
  logic [POS_W-1:0]  slot_pos [NKEYS*NPOS];
  int                num_keys;

  skit_rsp_t         rsp_expected_q [$];
  logic [KEY_W-1:0]  key_pool [$];
  int                errors;
  int                words_sent;
  int                words_checked;
  bit                no_idle;

  initial begin
    req_if.valid = 1'b0;
    req_if.data  = '0;
    rsp_if.ready = 1'b0;
  end

  function automatic int pick_gap();
    if (no_idle) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
    return $urandom_range(5, 40);
  endfunction

  function automatic skit_rsp_t make_rsp(logic [1:0] st, logic [KEY_W-1:0] k,
                                         logic [POS_W-1:0] p, int cnt, bit lst);
    skit_rsp_t r;
    r.status  = st;
    r.key_out = k;
    r.pos_out = p;
    r.count   = cnt[COUNT_W-1:0];
    r.last    = lst;
    return r;
  endfunction

  // Queue the whole list of one entry
  task automatic queue_list(int e);
    for (int i = 0; i < tbl_len[e]; i++)
      rsp_expected_q.push_back(make_rsp(ST_OK, tbl_key[e], slot_pos[tbl_slot[e]*NPOS + i],
                                        tbl_len[e], i + 1 == tbl_len[e]));
  endtask

  // Predict the results of one accepted request and update the shadow table
  task automatic predict_request(skit_req_t rq);
    int e;
    e = 0;
    while (e < num_keys && tbl_key[e] < rq.key) e++;
    case (rq.req_type)
      REQ_PUT: begin
        if (e < num_keys && tbl_key[e] == rq.key) begin
          if (tbl_len[e] >= NPOS) begin
            rsp_expected_q.push_back(make_rsp(ST_LIST_FULL, rq.key, rq.pos, num_keys, 1'b1));
          end else begin
            slot_pos[tbl_slot[e]*NPOS + tbl_len[e]] = rq.pos;
            tbl_len[e]++;
            rsp_expected_q.push_back(make_rsp(ST_OK, rq.key, rq.pos, num_keys, 1'b1));
          end
        end else if (num_keys >= NKEYS) begin
          rsp_expected_q.push_back(make_rsp(ST_TABLE_FULL, rq.key, rq.pos, num_keys, 1'b1));
        end else begin
          for (int i = num_keys; i > e; i--) begin
            tbl_key[i]  = tbl_key[i-1];
            tbl_slot[i] = tbl_slot[i-1];
            tbl_len[i]  = tbl_len[i-1];
          end
          tbl_key[e]  = rq.key;
          tbl_slot[e] = num_keys;
          tbl_len[e]  = 1;
          slot_pos[num_keys*NPOS] = rq.pos;
          num_keys++;
          rsp_expected_q.push_back(make_rsp(ST_OK, rq.key, rq.pos, num_keys, 1'b1));
        end
      end
      REQ_GET_KEY: begin
        if (e < num_keys && tbl_key[e] == rq.key) queue_list(e);
        else rsp_expected_q.push_back(make_rsp(ST_NOT_FOUND, rq.key, '0, 0, 1'b1));
      end
      REQ_GET_RANK: begin
        if (rq.rank < num_keys) queue_list(rq.rank);
        else rsp_expected_q.push_back(make_rsp(ST_NOT_FOUND, '0, '0, 0, 1'b1));
      end
      default: ;
    endcase
  endtask

  // Drive one request word and wait for its handshake
  task automatic send_word(logic [1:0] rt, logic [KEY_W-1:0] k, logic [POS_W-1:0] p,
                           logic [RANK_W-1:0] rk);
    skit_req_t rq;
    int gap;
    rq.req_type = rt;
    rq.key      = k;
    rq.pos      = p;
    rq.rank     = rk;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= rq;
    do @(posedge clk); while (!(req_if.valid && req_if.ready));
    predict_request(rq);
    words_sent++;
  endtask

  function automatic logic [POS_W-1:0] rand_pos();
    return POS_W'({$urandom, $urandom});
  endfunction

  function automatic logic [KEY_W-1:0] rand_key();
    return KEY_W'($urandom);
  endfunction

  task automatic wait_drained();
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (rsp_expected_q.size() != 0) @(posedge clk);
  endtask

  // Receiver stalls: short most of the time, sometimes long
  initial begin
    int hold;
    forever begin
      @(negedge clk);
      if (no_idle || $urandom_range(0, 3) != 0) begin
        rsp_if.ready <= 1'b1;
      end else begin
        hold = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 50);
        rsp_if.ready <= 1'b0;
        repeat (hold - 1) @(negedge clk);
      end
    end
  end

  // Compare each result word with the oldest prediction
  always @(posedge clk) begin
    skit_rsp_t got;
    skit_rsp_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      got = rsp_if.data;
      if (rsp_expected_q.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, got);
        errors++;
      end else begin
        want = rsp_expected_q.pop_front();
        words_checked++;
        if (got.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
          errors++;
        end
        if (got.key_out !== want.key_out) begin
          $display("%0t: key_out expected %h actual %h", $time, want.key_out, got.key_out);
          errors++;
        end
        if (got.pos_out !== want.pos_out) begin
          $display("%0t: pos_out expected %h actual %h", $time, want.pos_out, got.pos_out);
          errors++;
        end
        if (got.count !== want.count) begin
          $display("%0t: count expected %0d actual %0d", $time, want.count, got.count);
          errors++;
        end
        if (got.last !== want.last) begin
          $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
          errors++;
        end
      end
    end
  end

  // Empty table, key and position extremes, not found, bad rank, ignored code
  task automatic test_directed();
    send_word(REQ_GET_KEY, '0, '0, '0);
    send_word(REQ_GET_RANK, '0, '0, '0);
    send_word(REQ_PUT, '0, '0, '0);
    send_word(REQ_PUT, '1, '1, '0);
    send_word(REQ_PUT, 31'h2AAA_AAAA, 63'h5555_5555_5555_5555, '0);
    send_word(REQ_PUT, 31'h5555_5555, 63'h2AAA_AAAA_AAAA_AAAA, '0);
    send_word(REQ_PUT, '0, 63'h1, '0);
    send_word(REQ_IGNORED, '1, '1, '1);
    send_word(REQ_GET_KEY, '0, '1, '1);
    send_word(REQ_GET_KEY, '1, '0, '0);
    send_word(REQ_GET_KEY, 31'h1234_5678, '0, '0);
    send_word(REQ_GET_RANK, '0, '0, 8'd1);
    send_word(REQ_GET_RANK, '0, '0, 8'd4);
    send_word(REQ_GET_RANK, '1, '1, '1);
    wait_drained();
  endtask

  // Fill one list to the limit, then overflow it
  task automatic test_list_full();
    no_idle = 1'b1;
    for (int i = 0; i < NPOS; i++) send_word(REQ_PUT, '1, rand_pos(), '0);
    no_idle = 1'b0;
    send_word(REQ_PUT, '1, rand_pos(), '0);
    send_word(REQ_GET_KEY, '1, '0, '0);
    send_word(REQ_GET_RANK, '0, '0, 8'd3);
    wait_drained();
  endtask

  // Random mix over a small key pool so lists grow and ranks hit
  task automatic test_random(int n);
    int sel;
    logic [KEY_W-1:0] k;
    for (int i = 0; i < 12; i++) key_pool.push_back(rand_key());
    key_pool.push_back('0);
    key_pool.push_back('1);
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 20) no_idle = ~no_idle;
      sel = $urandom_range(0, 9);
      k = ($urandom_range(0, 7) == 0) ? rand_key()
                                      : key_pool[$urandom_range(0, key_pool.size() - 1)];
      if (sel < 5) send_word(REQ_PUT, k, rand_pos(), RANK_W'($urandom));
      else if (sel < 7) send_word(REQ_GET_KEY, k, rand_pos(), RANK_W'($urandom));
      else if (sel < 9)
        send_word(REQ_GET_RANK, rand_key(), rand_pos(),
                  RANK_W'(($urandom_range(0, 3) == 0) ? $urandom
                                                      : $urandom_range(0, num_keys)));
      else send_word(REQ_IGNORED, rand_key(), rand_pos(), RANK_W'($urandom));
      if (i == n / 2) wait_drained();
    end
    no_idle = 1'b0;
    wait_drained();
  endtask

  initial begin
    errors = 0;
    words_sent = 0;
    words_checked = 0;
    no_idle = 1'b0;
    num_keys = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_list_full();
    test_random(95);
    repeat (400) @(posedge clk);
    $display("Sent %0d request words, checked %0d result words", words_sent, words_checked);
    $display("Covered puts, list overflow, gets by key and rank, misses, ignored codes");
    if (errors == 0 && rsp_expected_q.size() == 0) begin
      $display("tb_sorted_key_index_table_core: PASS");
    end else begin
      $display("tb_sorted_key_index_table_core: FAIL");
    end
    $finish;
  end

  initial begin
    #30000000;
    $display("Timeout with %0d result words outstanding", rsp_expected_q.size());
    $display("tb_sorted_key_index_table_core: FAIL");
    $finish;
  end

endmodule
